// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the gcd/lcm unit RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/gcl_pkg.sv -----
// Package for the gcd/lcm unit: widths, action codes, controller states and
// the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package gcl_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);
  localparam int IN_TDATA_WIDTH  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;

  localparam logic ACT_GCD = 1'b0;
  localparam logic ACT_LCM = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GCD_DIV,
    ST_EUCLID,
    ST_LCM_DIV,
    ST_MUL,
    ST_FINISH
  } gcl_state_e;

  typedef struct packed {
    logic load;          // capture operands and action
    logic div_init_gcd;  // divide x by y
    logic div_init_lcm;  // divide |a| by the gcd
    logic div_step;      // one restoring division step
    logic euclid_next;   // x <= y, y <= remainder
    logic mul;           // product of quotient and |b|
    logic out_load;      // write the output register
  } gcl_cmd_t;

  typedef struct packed {
    logic y_zero;
    logic any_zero;
    logic action;
    logic out_free;
  } gcl_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/gcd_lcm_unit_top.sv -----
// Top level of the gcd/lcm unit: stream ports, controller and datapath.
// Depends on gcl_pkg, gcl_ctrl and gcl_datapath.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: operand_a, operand_b; tuser: action
//   m_axis    out        tdata: result; tuser: overflow
//
// A gcd item runs n Euclid remainder steps and an lcm item adds a final
// division and a multiply; each division runs the shared
// one-bit-per-cycle restoring divider over all DATA_WIDTH quotient bits. An lcm with a
// zero operand skips the final division and multiply. Items are taken one at
// a time; the result waits in an output register, so the next item may start
// while it is still pending. Reset clears the controller and output valid.
`default_nettype none

module gcd_lcm_unit_top
  import gcl_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // operand_a [DATA_WIDTH-1:0], operand_b [2*DATA_WIDTH-1:DATA_WIDTH]
  input  wire logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
  // action [0]
  input  wire logic                       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // result [DATA_WIDTH-1:0]
  output logic [OUT_TDATA_WIDTH-1:0]      m_axis_tdata,
  // overflow [0]
  output logic                            m_axis_tuser
);

  gcl_cmd_t              cmd;
  gcl_status_t           status;
  logic [DATA_WIDTH-1:0] result;

  gcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gcl_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_action_i    (s_axis_tuser),
    .in_a_i         (s_axis_tdata[DATA_WIDTH-1:0]),
    .in_b_i         (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_result_o   (result),
    .out_overflow_o (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TDATA_WIDTH'(result);

endmodule

`default_nettype wire

// ----- rtl/core/gcl_datapath.sv -----
// Datapath of the gcd/lcm unit: operand magnitudes, Euclid registers, a shared
// bit-serial restoring divider, the lcm multiplier and the output register. Uses gcl_pkg.
`default_nettype none

module gcl_datapath
  import gcl_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire gcl_cmd_t                   cmd_i,
  output gcl_status_t                     status_o,
  input  wire logic                       in_action_i,
  input  wire logic [DATA_WIDTH-1:0]      in_a_i,
  input  wire logic [DATA_WIDTH-1:0]      in_b_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [DATA_WIDTH-1:0]           out_result_o,
  output logic                            out_overflow_o
);

  logic [DATA_WIDTH-1:0] mag_a_q, mag_b_q, mag_a_d, mag_b_d;
  logic                  neg_q, act_q;
  logic [DATA_WIDTH-1:0] x_q, y_q;
  logic [DATA_WIDTH-1:0] quo_q, dvs_q, rem_q;
  logic [PROD_WIDTH-1:0] prod_q;
  logic [DATA_WIDTH-1:0] res_q, res_d;
  logic                  ovf_q, ovf_d;
  logic                  out_valid_q, out_valid_d;

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  any_zero;

  // The most negative operand maps to 2^(W-1), which still fits W unsigned bits.
  assign mag_a_d = in_a_i[DATA_WIDTH-1] ? (~in_a_i + 1'b1) : in_a_i;
  assign mag_b_d = in_b_i[DATA_WIDTH-1] ? (~in_b_i + 1'b1) : in_b_i;

  assign trial = {rem_q, quo_q[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};

  assign any_zero = (mag_a_q == '0) || (mag_b_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_a_q <= mag_a_d;
      mag_b_q <= mag_b_d;
      neg_q   <= in_a_i[DATA_WIDTH-1] ^ in_b_i[DATA_WIDTH-1];
      act_q   <= in_action_i;
      x_q     <= mag_a_d;
      y_q     <= mag_b_d;
    end else if (cmd_i.euclid_next) begin
      x_q <= y_q;
      y_q <= rem_q;
    end

    if (cmd_i.div_init_gcd) begin
      quo_q <= x_q;
      dvs_q <= y_q;
      rem_q <= '0;
    end else if (cmd_i.div_init_lcm) begin
      quo_q <= mag_a_q;
      dvs_q <= x_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!diff[DATA_WIDTH]) begin
        rem_q <= diff[DATA_WIDTH-1:0];
        quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_q <= trial[DATA_WIDTH-1:0];
        quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
      end
    end

    if (cmd_i.mul) begin
      prod_q <= PROD_WIDTH'(quo_q) * PROD_WIDTH'(mag_b_q);
    end

    if (cmd_i.out_load) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
    end
  end

  always_comb begin
    res_d = '0;
    ovf_d = 1'b0;
    if (act_q == ACT_GCD) begin
      res_d = x_q;
      ovf_d = x_q[DATA_WIDTH-1];
    end else if (!any_zero) begin
      if (neg_q) begin
        res_d = ~prod_q[DATA_WIDTH-1:0] + 1'b1;
        ovf_d = prod_q > (PROD_WIDTH'(1) << (DATA_WIDTH - 1));
      end else begin
        res_d = prod_q[DATA_WIDTH-1:0];
        ovf_d = prod_q[PROD_WIDTH-1:DATA_WIDTH-1] != '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.y_zero   = (y_q == '0);
  assign status_o.any_zero = any_zero;
  assign status_o.action   = act_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_result_o   = res_q;
  assign out_overflow_o = ovf_q;

endmodule

`default_nettype wire

// ----- rtl/core/gcl_ctrl.sv -----
// Controller of the gcd/lcm unit: sequences Euclid iterations, the divider
// steps, the multiply and the output load. Uses gcl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gcl_ctrl
  import gcl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire gcl_status_t status_i,
  output gcl_cmd_t         cmd_o
);

  gcl_state_e           state_q, state_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                 last_step;

  assign last_step = (cnt_q == CNT_WIDTH'(DATA_WIDTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cnt_d = '0;
        if (!status_i.y_zero) begin
          cmd_o.div_init_gcd = 1'b1;
          state_d            = ST_GCD_DIV;
        end else if (status_i.action == ACT_LCM && !status_i.any_zero) begin
          cmd_o.div_init_lcm = 1'b1;
          state_d            = ST_LCM_DIV;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_GCD_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (last_step) begin
          state_d = ST_EUCLID;
        end
      end
      ST_EUCLID: begin
        cmd_o.euclid_next = 1'b1;
        state_d           = ST_CHECK;
      end
      ST_LCM_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (last_step) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_load_enters_check, clk_i, rst_ni, cmd_o.load, state_q == ST_CHECK, "load must be followed by the zero check")
  `ASSERT_HOLDS(a_out_load_free, clk_i, rst_ni, !cmd_o.out_load || status_i.out_free, "output register overwritten before transfer")
  `ASSERT_HOLDS(a_mul_after_div, clk_i, rst_ni, state_q != ST_MUL || $past(state_q) == ST_LCM_DIV, "multiply entered without a full lcm division")

endmodule

`default_nettype wire
